### rtl/pti_pkg.sv
// shared types and constants for the piecewise table interpolator
package pti_pkg;
  localparam int unsigned ValW = 32;
  localparam int unsigned CntW = 9;

  localparam logic ActWrite = 1'b0;
  localparam logic ActQuery = 1'b1;

  localparam logic RegMode   = 1'b0;
  localparam logic RegPoints = 1'b1;

  typedef enum logic [3:0] {
    StIdle,
    StRdFirst,
    StWtFirst,
    StRdLast,
    StWtLast,
    StScanRd,
    StScanWt,
    StPrevRd,
    StPrevWt,
    StDivGo,
    StDivide,
    StOut
  } state_e;

  typedef struct packed {
    logic start;
    logic busy;
  } div_ctl_t;
endpackage

### rtl/pti_if.sv
// valid/ready channel interfaces
interface pti_in_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [7:0]  point_index;
  logic [31:0] point_x;
  logic [31:0] point_y;
  logic [31:0] query_x;
  modport source (output valid, action, point_index, point_x, point_y, query_x, input ready);
  modport sink (input valid, action, point_index, point_x, point_y, query_x, output ready);
endinterface

interface pti_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] y_result;
  logic        empty_table;
  modport source (output valid, y_result, empty_table, input ready);
  modport sink (input valid, y_result, empty_table, output ready);
endinterface

interface pti_cfg_if;
  logic        valid;
  logic        ready;
  logic        index;
  logic [8:0]  data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### rtl/pti_ram.sv
// generic single port ram with registered read
module pti_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[addr_i] <= wdata_i;
    rdata_o <= mem_q[addr_i];
  end
endmodule

### rtl/pti_div.sv
// restoring divider, 64 by 32 bit, one quotient bit per cycle
module pti_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] num_i,
  input  logic [31:0] den_i,
  output pti_pkg::div_ctl_t ctl_o,
  output logic [63:0] quo_o
);
  logic [6:0]  cnt_q, cnt_d;
  logic [63:0] quo_q, quo_d;
  logic [32:0] rem_q, rem_d;
  logic [31:0] den_q, den_d;
  logic [32:0] trial;
  always_comb begin
    cnt_d = cnt_q;
    quo_d = quo_q;
    rem_d = rem_q;
    den_d = den_q;
    trial = {rem_q[31:0], quo_q[63]};
    if (start_i) begin
      cnt_d = 7'd64;
      quo_d = num_i;
      rem_d = '0;
      den_d = den_i;
    end else if (cnt_q != 7'd0) begin
      cnt_d = cnt_q - 7'd1;
      if (trial >= {1'b0, den_q}) begin
        rem_d = trial - {1'b0, den_q};
        quo_d = {quo_q[62:0], 1'b1};
      end else begin
        rem_d = trial;
        quo_d = {quo_q[62:0], 1'b0};
      end
    end
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end
  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end
  assign ctl_o.start = start_i;
  assign ctl_o.busy  = (cnt_q != 7'd0);
  assign quo_o = quo_q;
endmodule

### rtl/piecewise_table_interpolator.sv
// top level of the piecewise table interpolator
//
//  channel  dir  payload                                      transaction
//  in_ch    in   action, point_index, point_x/y, query_x      valid & ready
//  out_ch   out  y_result, empty_table                        valid & ready
//  cfg_ch   in   index (0 mode, 1 points), data               valid & ready
//
// a point write is taken in idle; a query on an empty table goes straight to the
// output, one at or below the first point reads slot 0 and one at or above the
// last point reads the last slot; otherwise slots are scanned linearly from 1
// (a read state and a wait state per slot on the ram read port), then the slot
// before is read; linear mode then launches the shift/subtract divide, step mode
// skips it; j is the segment end slot
// reset clears state, slot index, mode and point count; the datapath registers and
// the table stay undefined until written. one item at a time; input is not ready until the result is taken.
module piecewise_table_interpolator #(
  parameter int unsigned MAX_POINTS = 256
) (
  input  logic clk_i,
  input  logic rst_ni,
  pti_in_if.sink    in_ch,
  pti_out_if.source out_ch,
  pti_cfg_if.sink   cfg_ch
);
  localparam int unsigned AW = $clog2(MAX_POINTS);

  pti_pkg::state_e state_q, state_d;

  logic                  mode_q;
  logic [8:0]            npts_q;
  logic [AW:0]           n_eff;
  logic [31:0]           q_q;
  logic [AW:0]           j_q, j_d;
  logic [31:0]           x1_q, y1_q, x0_q, y0_q;
  logic [31:0]           res_q;
  logic                  empty_q;
  logic                  div_start;
  pti_pkg::div_ctl_t     div_ctl;
  logic [63:0]           quo;
  logic                  we;
  logic [AW-1:0]         addr;
  logic [63:0]           rdata;
  logic [31:0]           rx, ry, dy, dx, dq;
  logic                  down_q;

  assign rx = rdata[63:32];
  assign ry = rdata[31:0];

  // clamp point count to table depth
  always_comb begin
    if ({23'd0, npts_q} > MAX_POINTS) n_eff = (AW+1)'(MAX_POINTS);
    else n_eff = (AW+1)'(npts_q);
  end

  assign cfg_ch.ready = (state_q == pti_pkg::StIdle);
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
      npts_q <= '0;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      if (cfg_ch.index == pti_pkg::RegMode) mode_q <= cfg_ch.data[0];
      else npts_q <= cfg_ch.data;
    end
  end

  assign in_ch.ready = (state_q == pti_pkg::StIdle);
  // point writes outside the table are dropped
  assign we = in_ch.valid && in_ch.ready && (in_ch.action == pti_pkg::ActWrite)
              && ({24'd0, in_ch.point_index} < MAX_POINTS);

  // ram address select
  always_comb begin
    unique case (state_q)
      pti_pkg::StIdle:    addr = AW'(in_ch.point_index);
      pti_pkg::StRdFirst: addr = '0;
      pti_pkg::StRdLast:  addr = AW'(n_eff - 1'b1);
      pti_pkg::StPrevRd:  addr = AW'(j_q - 1'b1);
      default:            addr = AW'(j_q);
    endcase
  end

  pti_ram #(.Width(64), .Depth(MAX_POINTS)) u_ram (
    .clk_i, .we_i(we), .addr_i(addr),
    .wdata_i({in_ch.point_x, in_ch.point_y}), .rdata_o(rdata)
  );

  // operands come from registers loaded by the time the divide is launched
  assign dx = x1_q - x0_q;
  assign dq = q_q - x0_q;
  assign dy = down_q ? (y0_q - y1_q) : (y1_q - y0_q);

  pti_div u_div (
    .clk_i, .rst_ni, .start_i(div_start),
    .num_i(64'(dy) * 64'(dq)), .den_i(dx), .ctl_o(div_ctl), .quo_o(quo)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      pti_pkg::StIdle:
        if (in_ch.valid && in_ch.action == pti_pkg::ActQuery) begin
          state_d = (n_eff == '0) ? pti_pkg::StOut : pti_pkg::StRdFirst;
        end
      pti_pkg::StRdFirst: state_d = pti_pkg::StWtFirst;
      pti_pkg::StWtFirst: state_d = (q_q <= rx) ? pti_pkg::StOut : pti_pkg::StRdLast;
      pti_pkg::StRdLast:  state_d = pti_pkg::StWtLast;
      pti_pkg::StWtLast:  state_d = (q_q >= rx) ? pti_pkg::StOut : pti_pkg::StScanRd;
      pti_pkg::StScanRd:  state_d = pti_pkg::StScanWt;
      pti_pkg::StScanWt:
        if (j_q < n_eff - 1'b1 && q_q >= rx) state_d = pti_pkg::StScanRd;
        else state_d = pti_pkg::StPrevRd;
      pti_pkg::StPrevRd:  state_d = pti_pkg::StPrevWt;
      pti_pkg::StPrevWt:  state_d = mode_q ? pti_pkg::StOut : pti_pkg::StDivGo;
      pti_pkg::StDivGo:   state_d = pti_pkg::StDivide;
      pti_pkg::StDivide:
        if (!div_ctl.start && !div_ctl.busy) state_d = pti_pkg::StOut;
      pti_pkg::StOut:     if (out_ch.ready) state_d = pti_pkg::StIdle;
      default:            state_d = pti_pkg::StIdle;
    endcase
  end

  // outputs and datapath control
  always_comb begin
    j_d = j_q;
    div_start = 1'b0;
    unique case (state_q)
      pti_pkg::StIdle:   j_d = (AW+1)'(1);
      pti_pkg::StScanWt: if (j_q < n_eff - 1'b1 && q_q >= rx) j_d = j_q + 1'b1;
      pti_pkg::StDivGo:  div_start = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pti_pkg::StIdle;
      j_q     <= '0;
    end else begin
      state_q <= state_d;
      j_q     <= j_d;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      pti_pkg::StIdle: begin
        q_q <= in_ch.query_x;
        empty_q <= (n_eff == '0);
        res_q <= '0;
      end
      pti_pkg::StWtFirst: res_q <= ry;
      pti_pkg::StWtLast:  res_q <= ry;
      pti_pkg::StScanWt: begin
        x1_q <= rx;
        y1_q <= ry;
      end
      pti_pkg::StPrevWt: begin
        x0_q <= rx;
        y0_q <= ry;
        res_q <= ry;
        down_q <= (y1_q < ry);
      end
      pti_pkg::StDivide:
        if (!div_ctl.start && !div_ctl.busy) begin
          res_q <= down_q ? (y0_q - quo[31:0]) : (y0_q + quo[31:0]);
        end
      default: ;
    endcase
  end

  assign out_ch.valid       = (state_q == pti_pkg::StOut);
  assign out_ch.y_result    = res_q;
  assign out_ch.empty_table = empty_q;
endmodule
